@@ rtl/urf_pkg.sv @@
// urf_pkg: shared types, codes and constants of the unsigned radix formatter.
// No dependencies; used by every module under rtl/.
`default_nettype none

package urf_pkg;

  // Significant bits of the value input; bits above are ignored.
  localparam int VALUE_BITS = 64;
  localparam logic [63:0] VALUE_MASK = 64'(~64'd0 >> (64 - VALUE_BITS));

  // Digit word: 20 BCD digits, also holds 64 binary, 22 octal or 16 hex digits.
  localparam int W_BITS     = 80;
  localparam int BCD_DIGITS = W_BITS / 4;

  // Radix select codes
  localparam logic [2:0] RADIX_BIN    = 3'd0;
  localparam logic [2:0] RADIX_OCT    = 3'd1;
  localparam logic [2:0] RADIX_DEC    = 3'd2;
  localparam logic [2:0] RADIX_HEX_LO = 3'd3;
  localparam logic [2:0] RADIX_HEX_UP = 3'd4;

  // Size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // Digit counts held by the word before leading-zero removal
  localparam logic [6:0] NDIG_BIN = 7'd64;
  localparam logic [6:0] NDIG_OCT = 7'd22;
  localparam logic [6:0] NDIG_HEX = 7'd16;
  localparam logic [6:0] NDIG_DEC = 7'(BCD_DIGITS);

  // Output limit per conversion
  localparam logic [7:0] MAX_CHARS = 8'd64;

  // ASCII
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_X_LO  = 7'h78;
  localparam logic [6:0] CH_X_UP  = 7'h58;
  localparam logic [6:0] CH_A_LO  = 7'h61;
  localparam logic [6:0] CH_A_UP  = 7'h41;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DABBLE,
    S_NORM,
    S_LAYOUT,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SH_DABBLE,
    SH_BIN,
    SH_OCT,
    SH_HEX
  } shift_mode_t;

  // Character boundaries of one field, as running positions
  typedef struct packed {
    logic [7:0] lead_end;    // leading spaces end here
    logic [7:0] prefix_end;  // prefix end
    logic [7:0] zero_end;    // zero fill and precision zeros end
    logic [7:0] digit_end;   // digits end
    logic [7:0] total;       // whole field length
    logic [6:0] pre1;        // second prefix character
  } layout_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + 7'(d);
    end else begin
      digit_char = base + 7'(d - 4'd10);
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/urf_shift_unit.sv @@
// urf_shift_unit: the shared shifter. Does one double-dabble step or one
// digit shift of the digit word, and presents the top digit. Uses urf_pkg.
`default_nettype none

module urf_shift_unit (
  input  wire logic [urf_pkg::W_BITS-1:0] w_in,
  input  wire logic                       bin_msb,
  input  urf_pkg::shift_mode_t            mode,
  output logic      [urf_pkg::W_BITS-1:0] w_out,
  output logic      [3:0]                 top_digit
);

  logic [urf_pkg::W_BITS-1:0] adj;

  // add-3 correction on every BCD nibble that is 5 or more
  always_comb begin
    for (int i = 0; i < urf_pkg::BCD_DIGITS; i++) begin
      if (w_in[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = w_in[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = w_in[4*i +: 4];
      end
    end
  end

  always_comb begin
    case (mode)
      urf_pkg::SH_DABBLE: begin
        w_out     = {adj[urf_pkg::W_BITS-2:0], bin_msb};
        top_digit = w_in[urf_pkg::W_BITS-1 -: 4];
      end
      urf_pkg::SH_BIN: begin
        w_out     = {w_in[urf_pkg::W_BITS-2:0], 1'b0};
        top_digit = {3'b000, w_in[urf_pkg::W_BITS-1]};
      end
      urf_pkg::SH_OCT: begin
        w_out     = {w_in[urf_pkg::W_BITS-4:0], 3'b000};
        top_digit = {1'b0, w_in[urf_pkg::W_BITS-1 -: 3]};
      end
      default: begin
        w_out     = {w_in[urf_pkg::W_BITS-5:0], 4'b0000};
        top_digit = w_in[urf_pkg::W_BITS-1 -: 4];
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/urf_layout.sv @@
// urf_layout: works out pad, prefix and precision zero counts of one field
// and turns them into character boundaries. Uses urf_pkg.
`default_nettype none

module urf_layout (
  input  wire logic [6:0] nd,
  input  wire logic [6:0] precision,
  input  wire logic [6:0] min_width,
  input  wire logic [2:0] radix_sel,
  input  wire logic       alt_form,
  input  wire logic       zero_pad,
  input  wire logic       left_justify,
  input  wire logic       value_zero,
  output urf_pkg::layout_t lay
);

  logic       has_prec;
  logic       zfill;
  logic       is_hex;
  logic [7:0] nd8;
  logic [7:0] prec8;
  logic [7:0] fw8;
  logic [7:0] extra;
  logic [7:0] plen;
  logic [7:0] body;
  logic [7:0] pad;

  always_comb begin
    has_prec = ~precision[6];
    nd8      = {1'b0, nd};
    prec8    = {2'b00, precision[5:0]};
    fw8      = {1'b0, min_width};
    is_hex   = (radix_sel == urf_pkg::RADIX_HEX_LO) || (radix_sel == urf_pkg::RADIX_HEX_UP);

    extra = (has_prec && (prec8 > nd8)) ? prec8 - nd8 : 8'd0;

    plen = 8'd0;
    if (alt_form && !value_zero) begin
      if (radix_sel == urf_pkg::RADIX_OCT) begin
        // octal prefix is dropped when precision zeros already lead
        plen = (extra == 8'd0) ? 8'd1 : 8'd0;
      end else if (is_hex) begin
        plen = 8'd2;
      end
    end

    body  = plen + extra + nd8;
    pad   = (fw8 > body) ? fw8 - body : 8'd0;
    zfill = !left_justify && zero_pad && !has_prec;

    lay.lead_end   = (!left_justify && !zfill) ? pad : 8'd0;
    lay.prefix_end = lay.lead_end + plen;
    lay.zero_end   = lay.prefix_end + (zfill ? pad : 8'd0) + extra;
    lay.digit_end  = lay.zero_end + nd8;
    lay.total      = lay.digit_end + (left_justify ? pad : 8'd0);
    lay.pre1       = (radix_sel == urf_pkg::RADIX_HEX_UP) ? urf_pkg::CH_X_UP
                                                          : urf_pkg::CH_X_LO;
  end

endmodule

`default_nettype wire

@@ rtl/unsigned_radix_formatter.sv @@
// unsigned_radix_formatter: printf-style unsigned conversion, one character per transfer.
// Steps: decimal items pass S_DABBLE first; S_NORM strips leading zero digits (up to 63,
// binary); S_LAYOUT fixes the field, S_EMIT sends it. One shared shifter does the digits.
// Throughput: one item at a time; its characters (at most 64) leave at one per cycle
// while char_ready is high, and item_ready returns the cycle after the last one.
// Reset: rst (synchronous) returns the sequencer to idle; item_ready rises next.
`default_nettype none

module unsigned_radix_formatter (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [63:0] value,
  input  wire logic [1:0]  size_code,
  input  wire logic [2:0]  radix_sel,
  input  wire logic [6:0]  min_width,
  input  wire logic signed [6:0] precision,
  input  wire logic        alt_form,
  input  wire logic        zero_pad,
  input  wire logic        left_justify,
  // character channel
  output logic             char_valid,
  input  wire logic        char_ready,
  output logic [6:0]       character,
  output logic             last
);

  // Sequencer state
  urf_pkg::state_t state, state_next;

  // Digit word: BCD digits for decimal, raw bit groups otherwise, top digit first
  logic [urf_pkg::W_BITS-1:0] w, w_next;
  // Binary source shifted out during double dabble
  logic [63:0] bin, bin_next;
  logic [5:0]  cnt, cnt_next;
  // Digit count still in the word
  logic [6:0]  nd, nd_next;
  urf_pkg::shift_mode_t dig_mode, dig_mode_next;

  // Captured item fields
  logic [6:0] fw_r, fw_r_next;
  logic [6:0] prec_r, prec_r_next;
  logic [2:0] radix_r, radix_r_next;
  logic       alt_r, alt_r_next;
  logic       zpad_r, zpad_r_next;
  logic       left_r, left_r_next;
  logic       vzero, vzero_next;

  urf_pkg::layout_t lay, lay_next, lay_c;
  logic [7:0] pos, pos_next;

  // Shared shifter hookup
  urf_pkg::shift_mode_t       sh_mode;
  logic [urf_pkg::W_BITS-1:0] w_out;
  logic [3:0]                 top_digit;

  logic [63:0] vm;
  logic        item_xfer;
  logic        char_xfer;
  logic        in_digits;

  assign sh_mode = (state == urf_pkg::S_DABBLE) ? urf_pkg::SH_DABBLE : dig_mode;

  urf_shift_unit u_shift (
    .w_in      (w),
    .bin_msb   (bin[63]),
    .mode      (sh_mode),
    .w_out     (w_out),
    .top_digit (top_digit)
  );

  urf_layout u_layout (
    .nd           (nd),
    .precision    (prec_r),
    .min_width    (fw_r),
    .radix_sel    (radix_r),
    .alt_form     (alt_r),
    .zero_pad     (zpad_r),
    .left_justify (left_r),
    .value_zero   (vzero),
    .lay          (lay_c)
  );

  assign item_ready = (state == urf_pkg::S_IDLE);
  assign char_valid = (state == urf_pkg::S_EMIT);
  assign item_xfer  = item_valid && item_ready;
  assign char_xfer  = char_valid && char_ready;

  // Value truncated to the argument size
  always_comb begin
    vm = value & urf_pkg::VALUE_MASK;
    case (size_code)
      urf_pkg::SIZE_8:  vm = vm & 64'h0000_0000_0000_00FF;
      urf_pkg::SIZE_16: vm = vm & 64'h0000_0000_0000_FFFF;
      urf_pkg::SIZE_32: vm = vm & 64'h0000_0000_FFFF_FFFF;
      default:          vm = vm;
    endcase
  end

  // Character at the current position; everything here is held while stalled
  assign in_digits = (pos >= lay.zero_end) && (pos < lay.digit_end);
  always_comb begin
    if (pos < lay.lead_end) begin
      character = urf_pkg::CH_SPACE;
    end else if (pos < lay.prefix_end) begin
      character = (pos == lay.lead_end) ? urf_pkg::CH_ZERO : lay.pre1;
    end else if (pos < lay.zero_end) begin
      character = urf_pkg::CH_ZERO;
    end else if (pos < lay.digit_end) begin
      character = urf_pkg::digit_char(top_digit, radix_r == urf_pkg::RADIX_HEX_UP);
    end else begin
      character = urf_pkg::CH_SPACE;
    end
  end

  // Field ends at its own length or at the 64-character cap
  assign last = (pos == lay.total - 8'd1) || (pos == urf_pkg::MAX_CHARS - 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    w        <= w_next;
    bin      <= bin_next;
    cnt      <= cnt_next;
    nd       <= nd_next;
    dig_mode <= dig_mode_next;
    fw_r     <= fw_r_next;
    prec_r   <= prec_r_next;
    radix_r  <= radix_r_next;
    alt_r    <= alt_r_next;
    zpad_r   <= zpad_r_next;
    left_r   <= left_r_next;
    vzero    <= vzero_next;
    lay      <= lay_next;
    pos      <= pos_next;
  end

  always_comb begin
    state_next    = state;
    w_next        = w;
    bin_next      = bin;
    cnt_next      = cnt;
    nd_next       = nd;
    dig_mode_next = dig_mode;
    fw_r_next     = fw_r;
    prec_r_next   = prec_r;
    radix_r_next  = radix_r;
    alt_r_next    = alt_r;
    zpad_r_next   = zpad_r;
    left_r_next   = left_r;
    vzero_next    = vzero;
    lay_next      = lay;
    pos_next      = pos;

    case (state)
      urf_pkg::S_IDLE: begin
        if (item_xfer) begin
          fw_r_next    = min_width;
          prec_r_next  = precision;
          radix_r_next = radix_sel;
          alt_r_next   = alt_form;
          zpad_r_next  = zero_pad;
          left_r_next  = left_justify;
          vzero_next   = (vm == 64'd0);
          bin_next     = vm;
          cnt_next     = 6'd0;
          state_next   = urf_pkg::S_NORM;
          case (radix_sel)
            urf_pkg::RADIX_BIN: begin
              w_next        = {vm, 16'd0};
              nd_next       = urf_pkg::NDIG_BIN;
              dig_mode_next = urf_pkg::SH_BIN;
            end
            urf_pkg::RADIX_OCT: begin
              w_next        = {2'b00, vm, 14'd0};
              nd_next       = urf_pkg::NDIG_OCT;
              dig_mode_next = urf_pkg::SH_OCT;
            end
            urf_pkg::RADIX_HEX_LO, urf_pkg::RADIX_HEX_UP: begin
              w_next        = {vm, 16'd0};
              nd_next       = urf_pkg::NDIG_HEX;
              dig_mode_next = urf_pkg::SH_HEX;
            end
            default: begin
              // decimal, and the unused codes converted as decimal
              w_next        = '0;
              nd_next       = urf_pkg::NDIG_DEC;
              dig_mode_next = urf_pkg::SH_HEX;
              state_next    = urf_pkg::S_DABBLE;
            end
          endcase
        end
      end

      urf_pkg::S_DABBLE: begin
        // one binary bit into the BCD word per cycle
        w_next   = w_out;
        bin_next = {bin[62:0], 1'b0};
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = urf_pkg::S_NORM;
        end
      end

      urf_pkg::S_NORM: begin
        // strip leading zero digits, keep at least one
        if ((nd > 7'd1) && (top_digit == 4'd0)) begin
          w_next  = w_out;
          nd_next = nd - 7'd1;
        end else begin
          // zero value with zero precision prints no digits
          if ((prec_r == 7'd0) && vzero) begin
            nd_next = 7'd0;
          end
          state_next = urf_pkg::S_LAYOUT;
        end
      end

      urf_pkg::S_LAYOUT: begin
        lay_next = lay_c;
        pos_next = 8'd0;
        state_next = (lay_c.total == 8'd0) ? urf_pkg::S_IDLE : urf_pkg::S_EMIT;
      end

      urf_pkg::S_EMIT: begin
        if (char_xfer) begin
          pos_next = pos + 8'd1;
          if (in_digits) begin
            w_next = w_out;
          end
          if (last) begin
            state_next = urf_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = urf_pkg::S_IDLE;
      end
    endcase
  end

  // Items and characters never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && char_valid))
    else $error("item_ready and char_valid high together");

  // Final character of a field frees the block for the next item
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && last) |=> item_ready)
    else $error("block not ready after last character transfer");

  // A taken item closes the item channel until its field is done
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item_ready stayed high after an item transfer");

  // Emission only with a nonempty field inside the character cap
  a_pos_in_field: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((pos < lay.total) && (pos < urf_pkg::MAX_CHARS)))
    else $error("character position outside the field");

endmodule

`default_nettype wire
